@@ rtl/core/dsp_pkg.sv @@
package dsp_pkg;

  localparam int unsigned FACTOR_W = 26;
  localparam int unsigned PROD_W   = 32 + FACTOR_W;

  localparam logic [31:0] INVALID_TOTAL = 32'h8000_0000;
  localparam logic [31:0] POS_LIMIT     = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT     = 32'h8000_0000;

  localparam int SECS_MIN  = 60;
  localparam int SECS_HOUR = 60 * SECS_MIN;
  localparam int SECS_DAY  = 24 * SECS_HOUR;
  localparam int SECS_WEEK = 7 * SECS_DAY;
  localparam int SECS_YEAR = 365 * SECS_DAY;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_M  = 8'h6D;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_W  = 8'h77;
  localparam logic [7:0] CH_LO_Y  = 8'h79;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [3:0] {
    PH_NUM_WS,
    PH_SIGN,
    PH_DIGITS,
    PH_UNIT_WS,
    PH_WORD,
    PH_SPACES,
    PH_AND,
    PH_AFTER_AND,
    PH_ERROR
  } dsp_phase_t;

  typedef enum logic [2:0] {
    U_YEAR,
    U_WEEK,
    U_DAY,
    U_HOUR,
    U_MIN,
    U_SEC
  } dsp_unit_t;

  typedef struct packed {
    logic       is_ws;
    logic       is_space;
    logic       is_alpha;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_plus;
    logic       is_minus;
    logic       is_comma;
    logic       is_a;
    logic       is_n;
    logic       is_d;
    logic       unit_valid;
    dsp_unit_t  unit;
  } dsp_cls_t;

  typedef struct packed {
    logic        mul_go;
    dsp_unit_t   unit;
    logic [31:0] snum;
    logic        dig_ovf;
    logic        end_go;
    logic        end_add;
    logic        end_err;
  } dsp_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] total;
    logic        error;
    logic        ovf;
  } dsp_res_t;

  function automatic logic signed [FACTOR_W-1:0] unit_factor(dsp_unit_t u);
    logic signed [FACTOR_W-1:0] f;
    case (u)
      U_YEAR:  f = FACTOR_W'(SECS_YEAR);
      U_WEEK:  f = FACTOR_W'(SECS_WEEK);
      U_DAY:   f = FACTOR_W'(SECS_DAY);
      U_HOUR:  f = FACTOR_W'(SECS_HOUR);
      U_MIN:   f = FACTOR_W'(SECS_MIN);
      U_SEC:   f = FACTOR_W'(1);
      default: f = FACTOR_W'(1);
    endcase
    return f;
  endfunction

endpackage

@@ rtl/core/dsp_ifs.sv @@
interface dsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_end;

  modport source(output valid, output char_byte, output is_end, input ready);
  modport sink(input valid, input char_byte, input is_end, output ready);
endinterface

interface dsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] total_seconds;
  logic               parse_error;
  logic               overflow;

  modport source(output valid, output total_seconds, output parse_error, output overflow,
                 input ready);
  modport sink(input valid, input total_seconds, input parse_error, input overflow,
               output ready);
endinterface

@@ rtl/core/dsp_char_class.sv @@
module dsp_char_class (
  input  logic [7:0]        char_byte,
  output dsp_pkg::dsp_cls_t cls
);
  import dsp_pkg::*;

  logic [7:0] lc;
  logic       is_upper;

  always_comb begin
    is_upper       = (char_byte >= CH_UP_A) && (char_byte <= CH_UP_Z);
    lc             = is_upper ? (char_byte | CASE_BIT) : char_byte;
    cls.is_space   = (char_byte == CH_SPACE);
    cls.is_ws      = cls.is_space || ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
    cls.is_alpha   = is_upper || ((char_byte >= CH_LO_A) && (char_byte <= CH_LO_Z));
    cls.is_digit   = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    cls.digit      = 4'(char_byte - CH_ZERO);
    cls.is_plus    = (char_byte == CH_PLUS);
    cls.is_minus   = (char_byte == CH_MINUS);
    cls.is_comma   = (char_byte == CH_COMMA);
    // The joining word is matched in lower case only.
    cls.is_a       = (char_byte == CH_LO_A);
    cls.is_n       = (char_byte == CH_LO_N);
    cls.is_d       = (char_byte == CH_LO_D);
    cls.unit_valid = 1'b1;
    case (lc)
      CH_LO_Y: cls.unit = U_YEAR;
      CH_LO_W: cls.unit = U_WEEK;
      CH_LO_D: cls.unit = U_DAY;
      CH_LO_H: cls.unit = U_HOUR;
      CH_LO_M: cls.unit = U_MIN;
      CH_LO_S: cls.unit = U_SEC;
      default: begin
        cls.unit       = U_SEC;
        cls.unit_valid = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/dsp_parse_fsm.sv @@
module dsp_parse_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              is_end,
  input  dsp_pkg::dsp_cls_t cls,
  output dsp_pkg::dsp_req_t req
);
  import dsp_pkg::*;

  dsp_phase_t  phase_r, phase_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic        neg_r, neg_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        err_r, err_nxt;

  // Outcome of starting a number with the current byte.
  dsp_phase_t  ns_phase;
  logic        ns_load;
  logic        ns_neg;
  logic [31:0] ns_cur;
  logic        ns_fail;

  // Outcome of the byte in the gap between terms.
  dsp_phase_t  sp_phase;
  logic        sp_and;
  logic        sp_num;

  logic [35:0] dig_next;
  logic [31:0] limit;
  logic        mul_go;
  logic        dig_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NUM_WS;
      cur_r   <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    ns_phase = PH_NUM_WS;
    ns_load  = 1'b0;
    ns_neg   = 1'b0;
    ns_cur   = '0;
    ns_fail  = 1'b0;
    if (cls.is_ws) begin
      ns_phase = PH_NUM_WS;
    end else if (cls.is_plus || cls.is_minus) begin
      ns_phase = PH_SIGN;
      ns_load  = 1'b1;
      ns_neg   = cls.is_minus;
    end else if (cls.is_digit) begin
      ns_phase = PH_DIGITS;
      ns_load  = 1'b1;
      ns_cur   = 32'(cls.digit);
    end else begin
      ns_phase = PH_ERROR;
      ns_fail  = 1'b1;
    end

    sp_and = 1'b0;
    sp_num = 1'b0;
    if (cls.is_space) begin
      sp_phase = PH_SPACES;
    end else if (cls.is_a) begin
      sp_phase = PH_AND;
      sp_and   = 1'b1;
    end else begin
      sp_phase = ns_phase;
      sp_num   = 1'b1;
    end

    dig_next = {1'b0, cur_r, 3'b000} + {3'b000, cur_r, 1'b0} + 36'(cls.digit);
    limit    = neg_r ? NEG_LIMIT : POS_LIMIT;
  end

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    mul_go    = 1'b0;
    dig_ovf   = 1'b0;

    if (is_end) begin
      phase_nxt = PH_NUM_WS;
      cur_nxt   = '0;
      neg_nxt   = 1'b0;
      cnt_nxt   = '0;
      err_nxt   = 1'b0;
    end else begin
      case (phase_r)
        PH_NUM_WS, PH_AFTER_AND: begin
          phase_nxt = ns_phase;
          if (ns_load) begin
            cur_nxt = ns_cur;
            neg_nxt = ns_neg;
          end
          if (ns_fail) begin
            err_nxt = 1'b1;
          end
        end
        PH_SIGN: begin
          if (cls.is_digit) begin
            phase_nxt = PH_DIGITS;
            cur_nxt   = 32'(cls.digit);
          end else begin
            phase_nxt = PH_ERROR;
            err_nxt   = 1'b1;
          end
        end
        PH_DIGITS, PH_UNIT_WS: begin
          if ((phase_r == PH_DIGITS) && cls.is_digit) begin
            cur_nxt = dig_next[31:0];
            dig_ovf = (dig_next > {4'b0000, limit});
          end else if (cls.is_space) begin
            phase_nxt = PH_UNIT_WS;
          end else if (cls.unit_valid) begin
            phase_nxt = PH_WORD;
            mul_go    = 1'b1;
          end else begin
            phase_nxt = PH_ERROR;
            err_nxt   = 1'b1;
          end
        end
        PH_WORD, PH_SPACES: begin
          if ((phase_r == PH_WORD) && cls.is_alpha) begin
            phase_nxt = PH_WORD;
          end else if ((phase_r == PH_WORD) && cls.is_comma) begin
            phase_nxt = PH_SPACES;
          end else begin
            phase_nxt = sp_phase;
            if (sp_and) begin
              cnt_nxt = 2'd1;
            end
            if (sp_num && ns_load) begin
              cur_nxt = ns_cur;
              neg_nxt = ns_neg;
            end
            if (sp_num && ns_fail) begin
              err_nxt = 1'b1;
            end
          end
        end
        PH_AND: begin
          if ((cnt_r == 2'd1) && cls.is_n) begin
            cnt_nxt = 2'd2;
          end else if ((cnt_r == 2'd2) && cls.is_d) begin
            cnt_nxt   = 2'd0;
            phase_nxt = PH_AFTER_AND;
          end else begin
            cnt_nxt   = 2'd0;
            phase_nxt = PH_ERROR;
            err_nxt   = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
          err_nxt   = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    req.mul_go  = accept && !is_end && mul_go;
    req.unit    = cls.unit;
    req.snum    = neg_r ? (32'd0 - cur_r) : cur_r;
    req.dig_ovf = accept && !is_end && dig_ovf;
    req.end_go  = accept && is_end;
    req.end_add = (phase_r == PH_DIGITS) || (phase_r == PH_UNIT_WS);
    req.end_err = err_r || !(phase_r inside {PH_DIGITS, PH_UNIT_WS, PH_WORD, PH_SPACES,
                                             PH_AFTER_AND});
  end

endmodule

@@ rtl/core/dsp_accum.sv @@
module dsp_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  dsp_pkg::dsp_req_t req,
  output dsp_pkg::dsp_res_t res
);
  import dsp_pkg::*;

  logic [31:0]              total_r, total_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     pend_v_r, pend_v_nxt;
  logic [31:0]              pend_r;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_ovf;
  logic                     add_en;
  logic [31:0]              addend;
  logic [32:0]              sum;
  logic                     add_ovf;
  logic [31:0]              tot_eff;
  logic                     ovf_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      ovf_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      total_r  <= total_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= prod[31:0];
  end

  always_comb begin
    prod     = $signed(req.snum) * unit_factor(req.unit);
    prod_ovf = (prod[PROD_W-1:31] != '0) && (prod[PROD_W-1:31] != '1);

    // A waiting product and a closing unitless number never coincide.
    add_en  = pend_v_r || (req.end_go && req.end_add);
    addend  = pend_v_r ? pend_r : req.snum;
    sum     = {total_r[31], total_r} + {addend[31], addend};
    add_ovf = sum[32] != sum[31];
    tot_eff = add_en ? sum[31:0] : total_r;
    ovf_eff = ovf_r || (add_en && add_ovf) || req.dig_ovf || (req.mul_go && prod_ovf);

    if (req.end_go) begin
      total_nxt  = '0;
      ovf_nxt    = 1'b0;
      pend_v_nxt = 1'b0;
    end else begin
      total_nxt  = tot_eff;
      ovf_nxt    = ovf_eff;
      pend_v_nxt = req.mul_go;
    end

    res.valid = req.end_go;
    res.total = req.end_err ? INVALID_TOTAL : tot_eff;
    res.error = req.end_err;
    res.ovf   = ovf_eff;
  end

endmodule

@@ rtl/core/duration_string_parser_top.sv @@
// Duration text parser.
// The input channel carries one character of a duration text per beat, for
// example "1y, 2w 3d and 4h5m6s"; a beat with is_end set closes the text and
// its char_byte is ignored. Each closing beat yields exactly one beat on the
// result channel with the total in seconds, a parse error flag and a sticky
// overflow flag; character beats yield nothing.
// Throughput is one beat per cycle while the output register is empty or being
// drained. Character beats are absorbed in the cycle they are accepted; the
// result appears on the output register in the cycle after the closing beat is
// accepted. A unit letter starts a constant multiply whose product is
// registered and then added into the running total, so the multiplier and
// the total adder each have a register stage of their own.
// The input is ready whenever the output register is empty or being
// drained, so a stalled receiver holds back new beats only while a result is
// waiting; character beats are still refused then, which keeps ordering
// simple. Synchronous reset returns the parser to the start of a text,
// clears the total and flags and empties the output register.
module duration_string_parser_top (
  input logic clk,
  input logic rst_n,
  dsp_in_if.sink    in_ch,
  dsp_out_if.source out_ch
);
  import dsp_pkg::*;

  dsp_cls_t    cls;
  dsp_req_t    req;
  dsp_res_t    res;
  logic        accept;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_total_r;
  logic        out_error_r;
  logic        out_ovf_r;

  // Ready depends only on the output register and the receiver's ready, never on the payload.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  dsp_char_class u_class (
    .char_byte (in_ch.char_byte),
    .cls       (cls)
  );

  dsp_parse_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .is_end (in_ch.is_end),
    .cls    (cls),
    .req    (req)
  );

  dsp_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  // Output register: loads on a closing beat, empties when the receiver
  // takes the result.
  always_comb begin
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_total_r <= res.total;
      out_error_r <= res.error;
      out_ovf_r   <= res.ovf;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.total_seconds = $signed(out_total_r);
  assign out_ch.parse_error   = out_error_r;
  assign out_ch.overflow      = out_ovf_r;

endmodule

@@ dv/duration_string_parser_top_test.sv @@
`default_nettype none

module duration_string_parser_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dsp_pkg::*;

  // The receiver's long hold-off, in clock cycles.
  localparam int HOLD_OFF_CYCLES = 150;
  localparam longint TOTAL_MAX   = 64'sd2147483647;
  localparam longint TOTAL_MIN   = -64'sd2147483648;

  // What one closing beat is expected to produce on the result channel.
  typedef struct {
    logic [31:0] total;
    logic        error;
    logic        ovf;
  } duration_result_t;

  logic clk;
  logic rst_n;

  dsp_in_if  in_ch();
  dsp_out_if out_ch();

  duration_string_parser_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The clock: 1 ns high, 1 ns low.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Totals still owed by the block, oldest first.
  duration_result_t totals_due[$];
  int               mismatches;
  int               results_seen;
  int               beats_sent;

  // When set, neither side idles; the random test sets it for a stretch.
  bit steady;
  // Asks the receiver process for one long hold-off.
  bit hold_req;

  // The text under construction in the random test.
  logic [7:0] text_buf[$];

  // ---------------------------------------------------------------------------
  // The parser as the testbench understands it. Each accepted beat updates this
  // copy of the state; a closing beat pushes the expected result.
  // ---------------------------------------------------------------------------
  dsp_phase_t  text_phase;
  logic [31:0] sum_acc;
  logic [31:0] magnitude;
  logic        mag_negative;
  logic [1:0]  and_letters;
  logic        err_seen;
  logic        ovf_seen;

  function automatic void clear_parser();
    text_phase   = PH_NUM_WS;
    sum_acc      = '0;
    magnitude    = '0;
    mag_negative = 1'b0;
    and_letters  = '0;
    err_seen     = 1'b0;
    ovf_seen     = 1'b0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Truncates to 32 bits, noting overflow if the value leaves the signed range.
  function automatic logic [31:0] fold_to_32(longint v);
    if (v > TOTAL_MAX || v < TOTAL_MIN) begin
      ovf_seen = 1'b1;
    end
    return v[31:0];
  endfunction

  // Multiplies the signed number by a unit's seconds and adds it to the sum.
  function automatic void accumulate(longint factor);
    logic [31:0] snum;
    logic [31:0] prod;
    snum    = mag_negative ? (32'd0 - magnitude) : magnitude;
    prod    = fold_to_32(longint'($signed(snum)) * factor);
    sum_acc = fold_to_32(longint'($signed(sum_acc)) + longint'($signed(prod)));
  endfunction

  function automatic void go_wrong();
    err_seen   = 1'b1;
    text_phase = PH_ERROR;
  endfunction

  function automatic void first_digit(logic [7:0] c);
    magnitude  = 32'(c - CH_ZERO);
    text_phase = PH_DIGITS;
  endfunction

  function automatic void next_digit(logic [7:0] c);
    logic [63:0] grown;
    logic [63:0] bound;
    grown = 64'(magnitude) * 64'd10 + 64'(c - CH_ZERO);
    bound = mag_negative ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
    if (grown > bound) begin
      ovf_seen = 1'b1;
    end
    magnitude = grown[31:0];
  endfunction

  // Start of a number: blanks are skipped, then a sign or a digit must come.
  function automatic void number_start(logic [7:0] c);
    if (is_blank(c)) begin
      return;
    end
    magnitude    = '0;
    mag_negative = 1'b0;
    if (c == CH_PLUS || c == CH_MINUS) begin
      mag_negative = (c == CH_MINUS);
      text_phase   = PH_SIGN;
    end else if (is_numeral(c)) begin
      first_digit(c);
    end else begin
      go_wrong();
    end
  endfunction

  // After the digits: plain spaces, then a unit letter in either case.
  function automatic void unit_letter(logic [7:0] c);
    logic [7:0] lc;
    longint     factor;
    if (c == CH_SPACE) begin
      text_phase = PH_UNIT_WS;
      return;
    end
    lc = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
    case (lc)
      CH_LO_Y: factor = SECS_YEAR;
      CH_LO_W: factor = SECS_WEEK;
      CH_LO_D: factor = SECS_DAY;
      CH_LO_H: factor = SECS_HOUR;
      CH_LO_M: factor = SECS_MIN;
      CH_LO_S: factor = 1;
      default: begin
        go_wrong();
        return;
      end
    endcase
    accumulate(factor);
    text_phase = PH_WORD;
  endfunction

  // Between terms: spaces, the start of "and", or the next number.
  function automatic void separator(logic [7:0] c);
    if (c == CH_SPACE) begin
      text_phase = PH_SPACES;
    end else if (c == CH_LO_A) begin
      and_letters = 2'd1;
      text_phase  = PH_AND;
    end else begin
      text_phase = PH_NUM_WS;
      number_start(c);
    end
  endfunction

  function automatic void parse_beat(logic [7:0] c, logic closing);
    duration_result_t r;
    if (closing) begin
      case (text_phase)
        PH_DIGITS, PH_UNIT_WS: accumulate(1);
        PH_WORD, PH_SPACES, PH_AFTER_AND: ;
        default: err_seen = 1'b1;
      endcase
      r.total = err_seen ? INVALID_TOTAL : sum_acc;
      r.error = err_seen;
      r.ovf   = ovf_seen;
      totals_due.push_back(r);
      clear_parser();
      return;
    end
    case (text_phase)
      PH_NUM_WS: number_start(c);
      PH_SIGN: begin
        if (is_numeral(c)) begin
          first_digit(c);
        end else begin
          go_wrong();
        end
      end
      PH_DIGITS: begin
        if (is_numeral(c)) begin
          next_digit(c);
        end else begin
          unit_letter(c);
        end
      end
      PH_UNIT_WS: unit_letter(c);
      PH_WORD: begin
        // The rest of the unit word is skipped; a comma may follow it directly.
        if (!is_letter(c)) begin
          if (c == CH_COMMA) begin
            text_phase = PH_SPACES;
          end else begin
            separator(c);
          end
        end
      end
      PH_SPACES: separator(c);
      PH_AND: begin
        if (and_letters == 2'd1 && c == CH_LO_N) begin
          and_letters = 2'd2;
        end else if (and_letters == 2'd2 && c == CH_LO_D) begin
          and_letters = 2'd0;
          text_phase  = PH_AFTER_AND;
        end else begin
          and_letters = 2'd0;
          go_wrong();
        end
      end
      PH_AFTER_AND: begin
        text_phase = PH_NUM_WS;
        number_start(c);
      end
      default: begin
        // Once in error, characters are swallowed until the closing beat.
        text_phase = PH_ERROR;
        err_seen   = 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Inputs change on the falling edge; acceptance is judged on the
  // rising edge, where valid and ready are both seen high. Idle cycles carry
  // junk on the payload so that nothing depends on it while valid is low.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] c, input logic closing);
    while (!steady && $urandom_range(99) < 34) begin
      @(negedge clk);
      in_ch.valid     = 1'b0;
      in_ch.char_byte = 8'($urandom);
      in_ch.is_end    = 1'($urandom);
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.char_byte = c;
    in_ch.is_end    = closing;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    parse_beat(c, closing);
    beats_sent++;
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], 1'b0);
    end
  endtask

  // The closing beat carries a random character, which the block must ignore.
  task automatic close_text();
    send_beat(8'($urandom), 1'b1);
  endtask

  task automatic send_text(input string s);
    send_chars(s);
    close_text();
  endtask

  task automatic send_buffer();
    foreach (text_buf[i]) begin
      send_beat(text_buf[i], 1'b0);
    end
    close_text();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. Ready is re-decided on every falling edge, idling about a
  // third of the time unless the steady stretch is on. A hold-off request keeps
  // ready low for a long, counted stretch so that a result sits in the output
  // register and the block has to refuse further beats.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_ch.ready = steady || ($urandom_range(99) >= 34);
    end
  end

  // Every result beat is checked against the oldest expected total.
  always @(posedge clk) begin
    duration_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (totals_due.size() == 0) begin
        $error("result beat with no text closed: total_seconds %0d",
               out_ch.total_seconds);
        mismatches++;
      end else begin
        exp_r = totals_due.pop_front();
        if (out_ch.total_seconds !== exp_r.total) begin
          $error("total_seconds: expected %0d, got %0d",
                 $signed(exp_r.total), out_ch.total_seconds);
          mismatches++;
        end
        if (out_ch.parse_error !== exp_r.error) begin
          $error("parse_error: expected %0b, got %0b", exp_r.error, out_ch.parse_error);
          mismatches++;
        end
        if (out_ch.overflow !== exp_r.ovf) begin
          $error("overflow: expected %0b, got %0b", exp_r.ovf, out_ch.overflow);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every unit in both cases, every kind of leading blank, signs, commas, the
  // joining word and a final number without a unit.
  task automatic test_units_and_joins();
    send_text("1y, 2w 3d and 4h5m6s");
    send_text("1Y2W3D4H5M6S");
    send_chars("\t\n\013\014\r +7 Hours,  and ");
    send_text("-8");
    send_text("-3 minutes 90");
    send_text("12 ");
    send_text("2d and");
    send_text("5 s,");
  endtask

  // Magnitudes at and just past the signed limits, products that overflow and
  // totals that wrap.
  task automatic test_number_limits();
    send_text("2147483647s");
    send_text("-2147483648");
    send_text("2147483648");
    send_text("-2147483649s");
    send_text("99999999999");
    send_text("68y");
    send_text("69y");
    send_text("2147483647s 1s");
    send_text("-2147483648s -1s");
  endtask

  // Empty text, stray characters, a sign with no digits, a word that is not a
  // unit, a broken "and", bytes with the top bit set, and junk after a fault.
  task automatic test_malformed_texts();
    close_text();
    send_text("x");
    send_text("+");
    send_text("--5");
    send_text("5q");
    send_text("3h an");
    send_text("3h ax1s");
    send_text("5 and 2s");
    send_text("1h,,2s");
    // An overflow before the fault must still be reported with the error.
    send_text("99999999999y !5s");
    send_text("1s?q1s2h");
    // A unit letter with the top bit set is not a letter.
    send_chars("5");
    send_beat(CH_LO_H | 8'h80, 1'b0);
    close_text();
    // Nor is a space with the top bit set a blank.
    send_beat(CH_SPACE | 8'h80, 1'b0);
    send_text("4s");
    send_beat(8'hFF, 1'b0);
    close_text();
  endtask

  // Appends a well-formed term list with random content to the text buffer.
  function automatic void build_duration();
    logic [7:0] blanks[6] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
    logic [7:0] units[6]  = '{CH_LO_Y, CH_LO_W, CH_LO_D, CH_LO_H, CH_LO_M, CH_LO_S};
    logic [7:0] u;
    int         terms;
    int         ndig;
    int         sp;
    bit         last;
    terms = $urandom_range(1, 4);
    for (int k = 0; k < terms; k++) begin
      last = (k == terms - 1);
      repeat ($urandom_range(0, 2)) text_buf.push_back(blanks[$urandom_range(0, 5)]);
      case ($urandom_range(0, 3))
        0: text_buf.push_back(CH_PLUS);
        1: text_buf.push_back(CH_MINUS);
        default: ;
      endcase
      // Mostly short numbers; now and then one long enough to overflow.
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 3);
      repeat (ndig) text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if (last && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(0, 1)) text_buf.push_back(CH_SPACE);
        return;
      end
      repeat ($urandom_range(0, 1)) text_buf.push_back(CH_SPACE);
      u = units[$urandom_range(0, 5)];
      text_buf.push_back($urandom_range(0, 1) ? (u & ~CASE_BIT) : u);
      // The rest of the unit word, in any case.
      repeat ($urandom_range(0, 3)) begin
        u = CH_LO_A + 8'($urandom_range(0, 25));
        text_buf.push_back($urandom_range(0, 1) ? (u & ~CASE_BIT) : u);
      end
      if (!last || $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 2) == 0) text_buf.push_back(CH_COMMA);
        sp = $urandom_range(0, 2);
        repeat (sp) text_buf.push_back(CH_SPACE);
        if (sp > 0 && $urandom_range(0, 2) == 0) begin
          text_buf.push_back(CH_LO_A);
          text_buf.push_back(CH_LO_N);
          text_buf.push_back(CH_LO_D);
          repeat ($urandom_range(0, 1)) text_buf.push_back(CH_SPACE);
        end
      end
    end
  endfunction

  // Mostly well-formed texts with random content; the rest are broken by a cut
  // or a corrupted byte, or are pure noise over the whole byte range. A stretch
  // in the middle runs with neither side idling.
  task automatic test_random_texts();
    int first_beat;
    int text_no;
    int pick;
    int pos;
    first_beat = beats_sent;
    text_no    = 0;
    while (beats_sent - first_beat < 345 || results_seen < 48) begin
      steady = (text_no >= 20 && text_no < 32);
      text_buf.delete();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        build_duration();
      end else if (pick < 92) begin
        build_duration();
        pos = $urandom_range(0, text_buf.size() - 1);
        if ($urandom_range(0, 1)) begin
          while (text_buf.size() > pos) void'(text_buf.pop_back());
        end else begin
          text_buf[pos] = 8'($urandom);
        end
      end else begin
        repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom));
      end
      send_buffer();
      text_no++;
    end
    steady = 1'b0;
  endtask

  // The receiver holds off for a long stretch while short texts keep coming, so
  // the first result waits in the output register and the input is refused.
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_text("5m");
    send_text("1h 2");
    send_text("-7s");
    send_text("3d");
    send_text("4");
    send_text("9W");
  endtask

  initial begin
    mismatches   = 0;
    results_seen = 0;
    beats_sent   = 0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    clear_parser();
    in_ch.valid     = 1'b0;
    in_ch.char_byte = '0;
    in_ch.is_end    = 1'b0;
    rst_n           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_units_and_joins();
    test_number_limits();
    test_malformed_texts();
    test_backpressure();
    test_random_texts();
    test_backpressure();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    // A further wait catches any result beat the block should not have sent.
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // This timeout stops a run that hangs, with an error.
  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/dsp_pkg.sv
rtl/core/dsp_ifs.sv
rtl/core/dsp_char_class.sv
rtl/core/dsp_parse_fsm.sv
rtl/core/dsp_accum.sv
rtl/core/duration_string_parser_top.sv
dv/duration_string_parser_top_test.sv
